// ===== sv/mfcrc_pkg.sv =====
`default_nettype none

package mfcrc_pkg;

  localparam int unsigned BitsW = 26;
  localparam int unsigned CntW  = 5;
  localparam int unsigned PreW  = 6;

  localparam logic [PreW-1:0] PreambleMax   = 6'd32;
  localparam logic [PreW-1:0] PreambleReset = 6'd32;
  localparam logic [7:0]      SyncReset     = 8'hC4;
  localparam logic [7:0]      CrcPoly       = 8'h8C;

  localparam logic [CntW-1:0] StartBits    = 5'd18;
  localparam logic [CntW-1:0] StartCrcBits = 5'd26;
  localparam logic [CntW-1:0] DataBits     = 5'd8;
  localparam logic [CntW-1:0] DataCrcBits  = 5'd16;

  // register indexes
  localparam logic RegSync     = 1'b0;
  localparam logic RegPreamble = 1'b1;

  // input commands
  localparam logic CmdStart = 1'b0;
  localparam logic CmdData  = 1'b1;

  // one queued burst of line bits, sent zeros first, then bits LSB first
  typedef struct packed {
    logic [PreW-1:0]  zeros;
    logic [BitsW-1:0] bits;
    logic [CntW-1:0]  nbits;
    logic             has_crc;
  } job_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mfcrc_in_if.sv =====
`default_nettype none

interface mfcrc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] frame_length;
  logic [7:0] payload_byte;

  modport source (output valid, output cmd, output frame_length, output payload_byte,
                  input ready);
  modport sink (input valid, input cmd, input frame_length, input payload_byte,
                output ready);
endinterface

`default_nettype wire

// ===== sv/mfcrc_out_if.sv =====
`default_nettype none

interface mfcrc_out_if;
  logic valid;
  logic ready;
  logic line_first_half;
  logic line_second_half;
  logic frame_done;
  logic last;

  modport source (output valid, output line_first_half, output line_second_half,
                  output frame_done, output last, input ready);
  modport sink (input valid, input line_first_half, input line_second_half,
                input frame_done, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/mfcrc_serializer.sv =====
`default_nettype none

module mfcrc_serializer
  import mfcrc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  input  wire job_t  job_i,
  output logic       job_ready_o,
  mfcrc_out_if.source out_o
);

  logic             act_q, act_d;
  logic [PreW-1:0]  zeros_q, zeros_d;
  logic [BitsW-1:0] bits_q, bits_d;
  logic [CntW-1:0]  nleft_q, nleft_d;
  logic             crc_q, crc_d;

  logic ovld_q, ovld_d;
  logic obit_q, obit_d;
  logic odone_q, odone_d;
  logic olast_q, olast_d;

  logic out_free, emit, final_bit, cur_bit;

  assign out_free  = !ovld_q || out_o.ready;
  assign emit      = act_q && out_free;
  assign final_bit = (zeros_q == '0) && (nleft_q == CntW'(1));
  assign cur_bit   = (zeros_q != '0) ? 1'b0 : bits_q[0];
  assign job_ready_o = !act_q || (emit && final_bit);

  always_comb begin
    act_d   = act_q;
    zeros_d = zeros_q;
    bits_d  = bits_q;
    nleft_d = nleft_q;
    crc_d   = crc_q;
    if (job_valid_i && job_ready_o) begin
      act_d   = 1'b1;
      zeros_d = job_i.zeros;
      bits_d  = job_i.bits;
      nleft_d = job_i.nbits;
      crc_d   = job_i.has_crc;
    end else if (emit) begin
      if (zeros_q != '0) begin
        zeros_d = zeros_q - PreW'(1);
      end else begin
        bits_d  = bits_q >> 1;
        nleft_d = nleft_q - CntW'(1);
        if (final_bit) begin
          act_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    ovld_d  = ovld_q;
    obit_d  = obit_q;
    odone_d = odone_q;
    olast_d = olast_q;
    if (out_free) begin
      ovld_d = emit;
      if (emit) begin
        obit_d  = cur_bit;
        olast_d = final_bit;
        odone_d = final_bit && crc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      act_q  <= act_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zeros_q <= zeros_d;
    bits_q  <= bits_d;
    nleft_q <= nleft_d;
    crc_q   <= crc_d;
    obit_q  <= obit_d;
    odone_q <= odone_d;
    olast_q <= olast_d;
  end

  assign out_o.valid            = ovld_q;
  assign out_o.line_first_half  = obit_q;
  assign out_o.line_second_half = ~obit_q;
  assign out_o.frame_done       = odone_q;
  assign out_o.last             = olast_q;

  a_active_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (nleft_q != '0))
    else $error("active burst with no bits left");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && odone_q |-> olast_q)
    else $error("frame_done on a word that is not last");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && final_bit && !job_valid_i |=> !act_q)
    else $error("serializer stays busy after final bit");

endmodule

`default_nettype wire

// ===== sv/manchester_frame_transmitter_crc8_core.sv =====
// Manchester frame transmitter with Dallas CRC-8 framing.
//
// in_i carries one word per command: cmd = 0 opens a frame of frame_length
// payload bytes, cmd = 1 carries payload_byte. out_o carries one word per
// line bit: the two half-bit levels, frame_done on the final CRC bit and
// last on the final bit caused by an input word. The user must write the
// registers (sync byte, preamble zero count) on cfg_we_i only while the
// block is idle; the block itself does not enforce this.
// A start word gives preamble + 18 bits, or preamble + 26 when the length is
// zero; a data word gives 8 bits, 16 on the last byte of a frame. The
// serializer sends one bit per cycle while out_o is ready. The first bit
// of a word passes the holding register, the serializer shift register
// and the output register before it shows on out_o; one word waits in the
// holding register while the previous one shifts out, so bursts follow each
// other with no gap. A data word with no frame open is accepted and dropped.
//
// Reset clears the frame state and empties the pipeline; the registers
// return to sync 0xC4 and 32 preamble zeros. When out_o stalls the current
// bit holds and the holding register fills, then in_i deasserts ready.
`default_nettype none

module manchester_frame_transmitter_crc8_core
  import mfcrc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  mfcrc_in_if.sink        in_i,
  mfcrc_out_if.source     out_o
);

  logic [7:0]      sync_q, sync_d;
  logic [PreW-1:0] pre_q, pre_d;

  logic [7:0] remaining_q, remaining_d;
  logic [7:0] crc_q, crc_d;
  logic       open_q, open_d;

  logic slot_valid_q, slot_valid_d;
  job_t slot_q, slot_d;

  logic job_ready, slot_take, accept, produce;
  logic [7:0] crc_len, crc_data;
  logic [PreW-1:0] zeros_sat;
  logic last_byte;

  always_comb begin
    sync_d = sync_q;
    pre_d  = pre_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSync:     sync_d = cfg_data_i;
        RegPreamble: pre_d  = cfg_data_i[PreW-1:0];
        default:     ;
      endcase
    end
  end

  assign slot_take  = slot_valid_q && job_ready;
  assign in_i.ready = !slot_valid_q || slot_take;
  assign accept     = in_i.valid && in_i.ready;
  assign produce    = accept && ((in_i.cmd == CmdStart) || open_q);

  assign crc_len   = crc8_update(8'h00, in_i.frame_length);
  assign crc_data  = crc8_update(crc_q, in_i.payload_byte);
  assign zeros_sat = (pre_q > PreambleMax) ? PreambleMax : pre_q;
  assign last_byte = (remaining_q == 8'd1);

  always_comb begin
    remaining_d = remaining_q;
    crc_d       = crc_q;
    open_d      = open_q;
    slot_d      = slot_q;
    if (produce) begin
      unique case (in_i.cmd)
        CmdStart: begin
          remaining_d    = in_i.frame_length;
          crc_d          = crc_len;
          open_d         = (in_i.frame_length != 8'd0);
          slot_d.zeros   = zeros_sat;
          slot_d.bits    = {crc_len, in_i.frame_length, sync_q, 2'b11};
          slot_d.has_crc = (in_i.frame_length == 8'd0);
          slot_d.nbits   = slot_d.has_crc ? StartCrcBits : StartBits;
        end
        CmdData: begin
          remaining_d    = remaining_q - 8'd1;
          crc_d          = crc_data;
          open_d         = !last_byte;
          slot_d.zeros   = '0;
          slot_d.bits    = {(BitsW-16)'(0), crc_data, in_i.payload_byte};
          slot_d.has_crc = last_byte;
          slot_d.nbits   = last_byte ? DataCrcBits : DataBits;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    slot_valid_d = slot_valid_q;
    if (produce) begin
      slot_valid_d = 1'b1;
    end else if (slot_take) begin
      slot_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q       <= SyncReset;
      pre_q        <= PreambleReset;
      remaining_q  <= 8'd0;
      crc_q        <= 8'd0;
      open_q       <= 1'b0;
      slot_valid_q <= 1'b0;
    end else begin
      sync_q       <= sync_d;
      pre_q        <= pre_d;
      remaining_q  <= remaining_d;
      crc_q        <= crc_d;
      open_q       <= open_d;
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  mfcrc_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (slot_valid_q),
    .job_i       (slot_q),
    .job_ready_o (job_ready),
    .out_o       (out_o)
  );

  a_open_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (remaining_q != 8'd0))
    else $error("frame open with no bytes remaining");

  a_slot_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_valid_q && !slot_take |=> slot_valid_q && $stable(slot_q))
    else $error("holding register lost a pending burst");

  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.cmd == CmdStart) |=> open_q == ($past(in_i.frame_length) != 8'd0))
    else $error("start word left frame state wrong");

endmodule

`default_nettype wire
